[hw/rtl/meu_pkg.sv]
package meu_pkg;

  localparam int unsigned IdW    = 11;
  localparam int unsigned AngleW = 16;
  localparam int unsigned TurnsW = 16;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned PosW   = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CpTW   = 16;
  localparam int unsigned ThrW   = 16;

  localparam logic [IdW-1:0]  BaseIdRst = 11'd513;
  localparam logic [ThrW-1:0] WrapThrRst = 16'd5000;
  localparam logic [CpTW-1:0] CpTRst     = 16'd8191;

  localparam logic signed [TurnsW-1:0] TurnsMax = 16'sh7fff;
  localparam logic signed [TurnsW-1:0] TurnsMin = 16'sh8000;

  typedef enum logic [1:0] {
    REG_BASE_ID   = 2'd0,
    REG_WRAP_THR  = 2'd1,
    REG_CNT_TURN  = 2'd2,
    REG_UNUSED    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [AngleW-1:0] angle;
    logic signed [TurnsW-1:0] turns;
  } ent_t;

endpackage

[hw/rtl/meu_if.sv]
interface meu_in_if;
  import meu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IdW-1:0]           frame_id;
  logic signed [AngleW-1:0] angle_raw;
  logic signed [SpeedW-1:0] speed_raw;

  modport source (output valid, frame_id, angle_raw, speed_raw, input ready);
  modport sink   (input valid, frame_id, angle_raw, speed_raw, output ready);
endinterface

interface meu_out_if #(
  parameter int unsigned ChW = 2
);
  import meu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ChW-1:0]           channel;
  logic signed [TurnsW-1:0] turns;
  logic signed [PosW-1:0]   position;
  logic signed [SpeedW-1:0] speed;

  modport source (output valid, channel, turns, position, speed, input ready);
  modport sink   (input valid, channel, turns, position, speed, output ready);
endinterface

[hw/rtl/meu_state_mem.sv]
module meu_state_mem import meu_pkg::*; #(
  parameter int unsigned Depth = 4,
  parameter int unsigned AddrW = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output ent_t             rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  ent_t             wr_data_i
);

  ent_t             mem [Depth];
  logic [Depth-1:0] written_q;
  ent_t             rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_en_i) begin
      written_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // bypass the write of the same edge so back-to-back beats on one channel chain
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else if (written_q[rd_addr_i]) begin
        rd_q <= mem[rd_addr_i];
      end else begin
        rd_q <= '0;
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

[hw/rtl/meu_out_fifo.sv]
module meu_out_fifo #(
  parameter int unsigned Width = 66,
  parameter int unsigned Depth = 4,
  parameter int unsigned PtrW  = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] buf_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_ptr_q];

endmodule

[hw/rtl/multi_turn_encoder_unwrap_top.sv]
// a matching frame's result is registered in stage 1, stage 2 and the output queue
// throughput: one frame per cycle while ready is high; the per-channel state
//   read-modify-write chains through a write bypass on the state memory
// ready drops once 4 matching frames are in flight or queued at the output
// reset: all channels read as zero angle and zero turns, registers take defaults
module multi_turn_encoder_unwrap_top import meu_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  meu_in_if.sink          frame_i,
  meu_out_if.source       result_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam int unsigned ChW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned OutW   = ChW + TurnsW + PosW + SpeedW;

  // configuration
  logic [IdW-1:0]  base_id_q;
  logic [ThrW-1:0] wrap_thr_q;
  logic [CpTW-1:0] cpt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_id_q  <= BaseIdRst;
      wrap_thr_q <= WrapThrRst;
      cpt_q      <= CpTRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BASE_ID:  base_id_q  <= cfg_data_i[IdW-1:0];
        REG_WRAP_THR: wrap_thr_q <= cfg_data_i[ThrW-1:0];
        REG_CNT_TURN: cpt_q      <= cfg_data_i[CpTW-1:0];
        default: ;
      endcase
    end
  end

  // decode and credit check
  logic [IdW:0]  id_off;
  logic          id_match;
  logic          in_fire, hit_fire;
  logic [QPtrW:0] occ_q;
  logic          pop;

  assign id_off   = {1'b0, frame_i.frame_id} - {1'b0, base_id_q};
  assign id_match = !id_off[IdW] && (id_off[IdW-1:0] < IdW'(NUM_CHANNELS));
  assign frame_i.ready = (occ_q < (QPtrW+1)'(QDepth));
  assign in_fire  = frame_i.valid && frame_i.ready;
  assign hit_fire = in_fire && id_match;

  // stage 1: state read returns
  logic                     s1_v_q;
  logic [ChW-1:0]           s1_ch_q;
  logic signed [AngleW-1:0] s1_angle_q;
  logic signed [SpeedW-1:0] s1_speed_q;
  ent_t                     rd_ent, wr_ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= hit_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_fire) begin
      s1_ch_q    <= id_off[ChW-1:0];
      s1_angle_q <= frame_i.angle_raw;
      s1_speed_q <= frame_i.speed_raw;
    end
  end

  meu_state_mem #(
    .Depth (NUM_CHANNELS),
    .AddrW (ChW)
  ) u_state_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (hit_fire),
    .rd_addr_i (id_off[ChW-1:0]),
    .rd_data_o (rd_ent),
    .wr_en_i   (s1_v_q),
    .wr_addr_i (s1_ch_q),
    .wr_data_i (wr_ent)
  );

  // rollover detection on the full-precision angle step
  logic signed [AngleW:0]   step;
  logic signed [AngleW:0]   thr_pos, thr_neg;
  logic signed [TurnsW-1:0] turns_new;

  always_comb begin
    step    = {s1_angle_q[AngleW-1], s1_angle_q} - {rd_ent.angle[AngleW-1], rd_ent.angle};
    thr_pos = {1'b0, wrap_thr_q};
    thr_neg = -thr_pos;
    turns_new = rd_ent.turns;
    if (step < thr_neg) begin
      if (rd_ent.turns != TurnsMax) turns_new = rd_ent.turns + 16'sd1;
    end else if (step > thr_pos) begin
      if (rd_ent.turns != TurnsMin) turns_new = rd_ent.turns - 16'sd1;
    end
  end

  assign wr_ent.angle = s1_angle_q;
  assign wr_ent.turns = turns_new;

  // stage 2: absolute position
  logic                     s2_v_q;
  logic [ChW-1:0]           s2_ch_q;
  logic signed [AngleW-1:0] s2_angle_q;
  logic signed [TurnsW-1:0] s2_turns_q;
  logic signed [SpeedW-1:0] s2_speed_q;
  logic signed [PosW+1:0]   pos_full;
  logic [OutW-1:0]          push_data, out_data;
  logic                     out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      s2_ch_q    <= s1_ch_q;
      s2_angle_q <= s1_angle_q;
      s2_turns_q <= turns_new;
      s2_speed_q <= s1_speed_q;
    end
  end

  assign pos_full = (PosW+2)'($signed({1'b0, cpt_q}) * s2_turns_q) + (PosW+2)'(s2_angle_q);
  assign push_data = {s2_ch_q, s2_turns_q, pos_full[PosW-1:0], s2_speed_q};

  meu_out_fifo #(
    .Width (OutW),
    .Depth (QDepth),
    .PtrW  (QPtrW)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_v_q),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (out_valid),
    .data_o      (out_data)
  );

  assign pop = out_valid && result_o.ready;

  // beats in flight plus queued results never exceed the queue depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + (QPtrW+1)'(hit_fire) - (QPtrW+1)'(pop);
    end
  end

  assign result_o.valid    = out_valid;
  assign result_o.channel  = out_data[OutW-1 -: ChW];
  assign result_o.turns    = out_data[PosW+SpeedW +: TurnsW];
  assign result_o.position = out_data[SpeedW +: PosW];
  assign result_o.speed    = out_data[SpeedW-1:0];

endmodule
